// File: rtl/owts_pkg.sv
// ============================================================================
// owts_pkg: shared types and constants
// Slot bytes, sensor command bytes, error codes, register indexes and the
// result record that passes from the controller to the output register.
// ============================================================================
package owts_pkg;

    // One-wire slot bytes as sent on the UART.
    localparam logic [7:0] SLOT_RESET = 8'hf0;
    localparam logic [7:0] SLOT_ONE   = 8'hff;
    localparam logic [7:0] SLOT_ZERO  = 8'h00;

    // Sensor command bytes.
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hcc;
    localparam logic [7:0] CMD_READ_PAD   = 8'hbe;
    localparam logic [7:0] CMD_WRITE_PAD  = 8'h4e;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;

    // Configuration register reset values.
    localparam logic [7:0] ALARM_RESET = 8'd127;
    localparam logic [7:0] SETUP_RESET = 8'b0100_0000;

    // Transfer lengths in bytes.
    localparam logic [3:0] LEN_READ    = 4'd11;
    localparam logic [3:0] LEN_CONFIG  = 4'd5;
    localparam logic [3:0] LEN_CONVERT = 4'd2;

    // Scratchpad positions of the temperature bytes.
    localparam int TEMP_LO_IDX = 2;
    localparam int TEMP_HI_IDX = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_SETUP = 2'd2;

    // Input operation codes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ECHO = 1'b1;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NODEV   = 2'd1,
        ERR_OVERRUN = 2'd2
    } t_err;

    // One result item without the temperature, which comes from the store.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       line_slow;
        logic       report_valid;
        logic       report_is_error;
        t_err       error_code;
    } t_result;

endpackage

// File: rtl/onewire_uart_temp_sequencer_top.sv
// ============================================================================
// onewire_uart_temp_sequencer_top: one-wire sensor reader over a UART
// Sequences scratchpad read, config write and convert transfers and
// reports the raw temperature or an error.
// ============================================================================
// Input channel (i_in_valid / o_in_stall): a tick (operation 0) starts a
// scratchpad read; an echo (operation 1) carries the byte read back from
// the line UART. Each transfer yields at most one result item.
// Output channel (o_out_valid / i_out_stall): a slot byte to send, the
// line speed to use and, at the end of a read, a temperature or error.
// A result passes from the input transfer through the result stage,
// loaded together with the store read, and then the output register.
// One item is taken every cycle while o_in_stall is low; each item does
// one sequencer state update, at most one store write and one paired read.
// When the receiver stalls, one result waits in the output register and
// one more in the result stage, after which o_in_stall rises.
// Reset (synchronous, active low) returns the sequencer to waiting, clears
// the pending error and sets the registers to defaults; i_cfg_we writes one.
// ============================================================================
module onewire_uart_temp_sequencer_top #(
    parameter int STORE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_tx_valid,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_line_slow,
    output logic                           o_report_valid,
    output logic                           o_report_is_error,
    output logic [1:0]                     o_error_code,
    output logic [15:0]                    o_temperature_raw
);
    import owts_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic          p_valid;
    t_result       p_res;
    logic          p_adv;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [7:0]    temp_lo;
    logic [7:0]    temp_hi;
    t_result       o_res;

    // Sequencer.
    owts_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .i_p_adv     (p_adv),
        .o_in_stall  (o_in_stall),
        .o_p_valid   (p_valid),
        .o_p         (p_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re)
    );

    // Frame store of echoed bytes.
    owts_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (AW'(TEMP_LO_IDX)),
        .i_raddr_b (AW'(TEMP_HI_IDX)),
        .o_rdata_a (temp_lo),
        .o_rdata_b (temp_hi)
    );

    // Output register.
    owts_outq u_outq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_p_valid         (p_valid),
        .i_p               (p_res),
        .i_temp_lo         (temp_lo),
        .i_temp_hi         (temp_hi),
        .i_out_stall       (i_out_stall),
        .o_p_adv           (p_adv),
        .o_out_valid       (o_out_valid),
        .o_res             (o_res),
        .o_temperature_raw (o_temperature_raw)
    );

    assign o_tx_valid        = o_res.tx_valid;
    assign o_tx_byte         = o_res.tx_byte;
    assign o_line_slow       = o_res.line_slow;
    assign o_report_valid    = o_res.report_valid;
    assign o_report_is_error = o_res.report_is_error;
    assign o_error_code      = o_res.error_code;

    // Every result carries a slot byte or a report.
    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tx_valid || o_report_valid))
        else $error("result without slot byte or report");

    // The reset pulse goes at slow speed, data slots at fast speed.
    a_reset_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_valid) |-> ((o_tx_byte == SLOT_RESET) == o_line_slow))
        else $error("slot byte sent at the wrong line speed");

    // An error report carries no temperature.
    a_error_no_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report_is_error) |-> (o_temperature_raw == 16'h0000))
        else $error("temperature shown with an error report");

    // With the output register empty the input is never held off.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with an empty output register");

endmodule

// File: rtl/owts_store.sv
// ============================================================================
// owts_store: frame store
// Synchronous memory of echoed bytes with one write port and two
// registered read ports.
// ============================================================================
module owts_store #(
    parameter int STORE_DEPTH = 16,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_a,
    output logic [7:0]    o_rdata_b
);

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rdata_a;
    logic [7:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports with registered data; a read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/owts_ctrl.sv
// ============================================================================
// owts_ctrl: transfer sequencer
// Runs the read, config and convert transfers, samples echoed slots into
// bytes for the frame store and registers at most one result per item.
// ============================================================================
module owts_ctrl #(
    parameter int STORE_DEPTH = 16,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_operation,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_p_adv,
    output logic                           o_in_stall,
    output logic                           o_p_valid,
    output owts_pkg::t_result              o_p,
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [7:0]                     o_mem_wdata,
    output logic                           o_mem_re
);
    import owts_pkg::*;

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_CONFIG  = 2'd1,
        ST_CONVERT = 2'd2,
        ST_READ    = 2'd3
    } t_stage;

    t_stage     r_stage, n_stage;
    logic       r_in_reset, n_in_reset;
    logic       r_active, n_active;
    logic [2:0] r_bit, n_bit;
    logic [3:0] r_byte, n_byte;
    logic [7:0] r_accum, n_accum;
    logic [3:0] r_len, n_len;
    t_err       r_perr, n_perr;
    logic       r_slow, n_slow;
    logic [7:0] r_alarm_high, r_alarm_low, r_setup;
    logic [7:0] r_snap_high, r_snap_low, r_snap_setup;
    logic       r_p_valid;
    t_result    r_p;
    t_result    n_res;
    logic       accept;
    logic       complete;
    logic       take_snap;
    logic       start;
    logic [3:0] start_len;
    logic [7:0] acc_upd;
    logic [7:0] frame;

    // Byte that a transfer sends at a given position.
    function automatic logic [7:0] frame_byte(input t_stage stage, input logic [3:0] idx,
                                              input logic [7:0] ah, input logic [7:0] al,
                                              input logic [7:0] ss);
        logic [7:0] b;
        b = SLOT_ONE;
        case (stage)
            ST_READ: begin
                case (idx)
                    4'd0:    b = CMD_SKIP_ROM;
                    4'd1:    b = CMD_READ_PAD;
                    default: b = SLOT_ONE;
                endcase
            end
            ST_CONFIG: begin
                case (idx)
                    4'd0:    b = CMD_SKIP_ROM;
                    4'd1:    b = CMD_WRITE_PAD;
                    4'd2:    b = ah;
                    4'd3:    b = al;
                    default: b = ss;
                endcase
            end
            ST_CONVERT: begin
                case (idx)
                    4'd0:    b = CMD_SKIP_ROM;
                    default: b = CMD_CONVERT;
                endcase
            end
            default: b = SLOT_ONE;
        endcase
        return b;
    endfunction

    // The result register takes a new item when empty or when it moves on.
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_in_stall = r_p_valid & ~i_p_adv;

    // Next state and result of the accepted item.
    always_comb begin
        n_stage     = r_stage;
        n_in_reset  = r_in_reset;
        n_active    = r_active;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_accum     = r_accum;
        n_len       = r_len;
        n_perr      = r_perr;
        n_slow      = r_slow;
        n_res       = '0;
        complete    = 1'b0;
        take_snap   = 1'b0;
        start       = 1'b0;
        start_len   = LEN_READ;
        acc_upd     = r_accum | (8'd1 << r_bit);
        frame       = 8'h00;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_byte[AW-1:0];
        o_mem_wdata = r_accum;

        if (accept) begin
            if (i_operation == OP_TICK) begin
                // A tick while a chain is still running counts as an overrun.
                if (r_stage != ST_WAIT) begin
                    n_perr = ERR_OVERRUN;
                end
                n_stage   = ST_READ;
                start     = 1'b1;
                start_len = LEN_READ;
            end else if (r_active) begin
                if (r_in_reset) begin
                    // Presence check: an unchanged reset byte means no device.
                    n_slow     = 1'b0;
                    n_in_reset = 1'b0;
                    if (i_rx_byte == SLOT_RESET) begin
                        n_perr   = ERR_NODEV;
                        n_active = 1'b0;
                        complete = 1'b1;
                    end
                end else begin
                    // Sample one bit, LSB first; a full byte goes to the store.
                    acc_upd = (i_rx_byte == SLOT_ONE) ? (r_accum | (8'd1 << r_bit)) : r_accum;
                    n_accum = acc_upd;
                    n_bit   = r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = acc_upd;
                        n_accum     = 8'h00;
                        n_byte      = r_byte + 4'd1;
                        if (n_byte == r_len) begin
                            n_active = 1'b0;
                            complete = 1'b1;
                        end
                    end
                end

                // Next slot of the running transfer.
                if (!complete) begin
                    frame          = frame_byte(r_stage, n_byte, r_snap_high,
                                                r_snap_low, r_snap_setup);
                    n_res.tx_valid = 1'b1;
                    n_res.tx_byte  = frame[n_bit] ? SLOT_ONE : SLOT_ZERO;
                end

                // Chain to the next transfer at the end of this one.
                if (complete) begin
                    case (r_stage)
                        ST_READ: begin
                            n_res.report_valid = 1'b1;
                            if (n_perr != ERR_OK) begin
                                n_res.report_is_error = 1'b1;
                                n_res.error_code      = n_perr;
                                n_perr                = ERR_OK;
                            end
                            take_snap = 1'b1;
                            n_stage   = ST_CONFIG;
                            start     = 1'b1;
                            start_len = LEN_CONFIG;
                        end
                        ST_CONFIG: begin
                            n_stage   = ST_CONVERT;
                            start     = 1'b1;
                            start_len = LEN_CONVERT;
                        end
                        ST_CONVERT: begin
                            n_stage = ST_WAIT;
                        end
                        default: begin
                            n_stage = r_stage;
                        end
                    endcase
                end
            end

            // A new transfer opens with the reset pulse at slow speed.
            if (start) begin
                n_in_reset     = 1'b1;
                n_bit          = 3'd0;
                n_byte         = 4'd0;
                n_accum        = 8'h00;
                n_len          = start_len;
                n_slow         = 1'b1;
                n_active       = 1'b1;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = SLOT_RESET;
            end
            n_res.line_slow = n_slow;
        end
    end

    // The temperature bytes are read on every transfer into the result stage.
    assign o_mem_re = accept;

    // Sequencer state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_WAIT;
            r_in_reset   <= 1'b0;
            r_active     <= 1'b0;
            r_bit        <= 3'd0;
            r_byte       <= 4'd0;
            r_accum      <= 8'h00;
            r_len        <= 4'd0;
            r_perr       <= ERR_OK;
            r_slow       <= 1'b0;
            r_alarm_high <= ALARM_RESET;
            r_alarm_low  <= ALARM_RESET;
            r_setup      <= SETUP_RESET;
        end else begin
            r_stage    <= n_stage;
            r_in_reset <= n_in_reset;
            r_active   <= n_active;
            r_bit      <= n_bit;
            r_byte     <= n_byte;
            r_accum    <= n_accum;
            r_len      <= n_len;
            r_perr     <= n_perr;
            r_slow     <= n_slow;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ALARM_HIGH:   r_alarm_high <= i_cfg_data;
                    REG_ALARM_LOW:    r_alarm_low  <= i_cfg_data;
                    REG_SENSOR_SETUP: r_setup      <= i_cfg_data;
                    default:          r_setup      <= r_setup;
                endcase
            end
        end
    end

    // The config frame is fixed when the read transfer ends.
    always_ff @(posedge i_clk) begin
        if (take_snap) begin
            r_snap_high  <= r_alarm_high;
            r_snap_low   <= r_alarm_low;
            r_snap_setup <= r_setup;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= n_res.tx_valid | n_res.report_valid;
        end else if (i_p_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p <= n_res;
        end
    end

    assign o_p_valid = r_p_valid;
    assign o_p       = r_p;

endmodule

// File: rtl/owts_outq.sv
// ============================================================================
// owts_outq: output register
// Holds one result item for the receiver and merges in the temperature
// bytes read from the frame store.
// ============================================================================
module owts_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_p_valid,
    input  owts_pkg::t_result i_p,
    input  logic [7:0]        i_temp_lo,
    input  logic [7:0]        i_temp_hi,
    input  logic              i_out_stall,
    output logic              o_p_adv,
    output logic              o_out_valid,
    output owts_pkg::t_result o_res,
    output logic [15:0]       o_temperature_raw
);
    import owts_pkg::*;

    logic        r_o_valid;
    t_result     r_o;
    logic [15:0] r_temp;

    // The result stage moves on when this register is empty or drains.
    assign o_p_adv = ~r_o_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_p_adv) begin
            r_o_valid <= i_p_valid;
        end
    end

    // Temperature is shown only on a report that is not an error.
    always_ff @(posedge i_clk) begin
        if (o_p_adv) begin
            r_o    <= i_p;
            r_temp <= (i_p.report_valid && !i_p.report_is_error) ?
                      {i_temp_hi, i_temp_lo} : 16'h0000;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_res             = r_o;
    assign o_temperature_raw = r_temp;

endmodule

// File: tb/tb_onewire_uart_temp_sequencer_top.sv
// ============================================================================
// tb_onewire_uart_temp_sequencer_top: self-checking bench for the sequencer
// Drives ticks and echoed line bytes into the sequencer. A behavioral copy of
// the read, config and convert chain predicts every slot byte and report.
// Each result transfer is compared field by field with the oldest
// prediction. Both channels idle at random. One phase holds off the output
// channel for a long stretch, and the register settings change between
// phases while the block is drained.
// ============================================================================
module tb_onewire_uart_temp_sequencer_top;

    timeunit 1ns;
    timeprecision 1ps;

    import owts_pkg::*;

    localparam int STORE_ENTRIES = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 850;
    localparam int REPORT_LINES  = 40;

    // Index past the end of the register list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STG_WAIT    = 2'd0,
        STG_CONFIG  = 2'd1,
        STG_CONVERT = 2'd2,
        STG_READ    = 2'd3
    } chain_stage_e;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        line_slow;
        logic        report_valid;
        logic        report_is_error;
        logic [1:0]  error_code;
        logic [15:0] temperature_raw;
    } line_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_operation = OP_TICK;
    logic [7:0]           i_rx_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_tx_valid;
    logic [7:0]           o_tx_byte;
    logic                 o_line_slow;
    logic                 o_report_valid;
    logic                 o_report_is_error;
    logic [1:0]           o_error_code;
    logic [15:0]          o_temperature_raw;

    // Predicted sequencer state and register copies.
    chain_stage_e seq_stage = STG_WAIT;
    logic         seq_in_reset = 1'b0;
    logic         seq_active = 1'b0;
    logic [2:0]   seq_bit = '0;
    logic [3:0]   seq_byte = '0;
    logic [7:0]   seq_accum = '0;
    logic [3:0]   seq_len = '0;
    t_err         seq_err = ERR_OK;
    logic         seq_slow = 1'b0;
    logic [7:0]   scratch [STORE_ENTRIES];
    logic [7:0]   cfg_alarm_high = ALARM_RESET;
    logic [7:0]   cfg_alarm_low = ALARM_RESET;
    logic [7:0]   cfg_setup = SETUP_RESET;

    line_result_t step_res;
    line_result_t oldest;
    line_result_t line_result_q [$];

    int          mismatch_count = 0;
    int          items_effective = 0;
    int          quiet_cycles = 0;
    logic        gaps_on = 1'b0;
    int          burst_left = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    stall_mode_e rx_mode = STALL_NONE;
    int          mode_left = 0;

    onewire_uart_temp_sequencer_top #(
        .STORE_DEPTH(STORE_ENTRIES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tx_valid       (o_tx_valid),
        .o_tx_byte        (o_tx_byte),
        .o_line_slow      (o_line_slow),
        .o_report_valid   (o_report_valid),
        .o_report_is_error(o_report_is_error),
        .o_error_code     (o_error_code),
        .o_temperature_raw(o_temperature_raw)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------

    // Opens a line frame with the reset pulse at slow speed.
    function automatic void open_frame(input logic [3:0] len);
        seq_in_reset = 1'b1;
        seq_bit = '0;
        seq_byte = '0;
        seq_accum = '0;
        seq_len = len;
        seq_slow = 1'b1;
        seq_active = 1'b1;
        step_res.tx_valid = 1'b1;
        step_res.tx_byte = SLOT_RESET;
    endfunction

    // Moves the chain on once a frame has ended: read, config, convert, wait.
    function automatic void finish_frame();
        case (seq_stage)
            STG_READ: begin
                step_res.report_valid = 1'b1;
                if (seq_err != ERR_OK) begin
                    step_res.report_is_error = 1'b1;
                    step_res.error_code = seq_err;
                    seq_err = ERR_OK;
                end else begin
                    step_res.temperature_raw = {scratch[TEMP_HI_IDX], scratch[TEMP_LO_IDX]};
                end
                scratch[0] = CMD_SKIP_ROM;
                scratch[1] = CMD_WRITE_PAD;
                scratch[2] = cfg_alarm_high;
                scratch[3] = cfg_alarm_low;
                scratch[4] = cfg_setup;
                seq_stage = STG_CONFIG;
                open_frame(LEN_CONFIG);
            end
            STG_CONFIG: begin
                scratch[0] = CMD_SKIP_ROM;
                scratch[1] = CMD_CONVERT;
                seq_stage = STG_CONVERT;
                open_frame(LEN_CONVERT);
            end
            STG_CONVERT: begin
                seq_stage = STG_WAIT;
            end
            default: begin
            end
        endcase
    endfunction

    // Applies one accepted item and queues the result it causes, if any.
    function automatic void predict_item(input logic op, input logic [7:0] rx);
        logic presence_slot;
        logic done;
        step_res = '0;
        done = 1'b0;
        if (op == OP_TICK) begin
            items_effective++;
            if (seq_stage != STG_WAIT) begin
                seq_err = ERR_OVERRUN;
            end
            seq_stage = STG_READ;
            scratch[0] = CMD_SKIP_ROM;
            scratch[1] = CMD_READ_PAD;
            // The nine scratchpad bytes are sampled with all-ones slots.
            for (int i = TEMP_LO_IDX; i < LEN_READ; i++) begin
                scratch[i] = '1;
            end
            open_frame(LEN_READ);
        end else if (seq_active) begin
            items_effective++;
            presence_slot = seq_in_reset;
            if (seq_in_reset) begin
                seq_slow = 1'b0;
                seq_in_reset = 1'b0;
                // An echoed reset pulse means nobody pulled the line low.
                if (rx == SLOT_RESET) begin
                    seq_err = ERR_NODEV;
                    seq_active = 1'b0;
                    finish_frame();
                    done = 1'b1;
                end
            end
            if (!done) begin
                if (!presence_slot) begin
                    if (rx == SLOT_ONE) begin
                        seq_accum[seq_bit] = 1'b1;
                    end
                    if (seq_bit == 3'd7) begin
                        seq_bit = '0;
                        scratch[seq_byte] = seq_accum;
                        seq_accum = '0;
                        seq_byte++;
                        if (seq_byte == seq_len) begin
                            seq_active = 1'b0;
                            finish_frame();
                            done = 1'b1;
                        end
                    end else begin
                        seq_bit++;
                    end
                end
                if (!done) begin
                    step_res.tx_valid = 1'b1;
                    step_res.tx_byte = scratch[seq_byte][seq_bit] ? SLOT_ONE : SLOT_ZERO;
                end
            end
        end
        step_res.line_slow = seq_slow;
        if (step_res.tx_valid || step_res.report_valid) begin
            line_result_q.push_back(step_res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    // Compares each result transfer with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_result_q.size() == 0) begin
                report_mismatch("result with none expected",
                                16'({o_tx_valid, o_tx_byte}), 16'h0000);
            end else begin
                oldest = line_result_q.pop_front();
                if (o_tx_valid !== oldest.tx_valid)
                    report_mismatch("tx_valid", 16'(o_tx_valid), 16'(oldest.tx_valid));
                if (o_tx_byte !== oldest.tx_byte)
                    report_mismatch("tx_byte", 16'(o_tx_byte), 16'(oldest.tx_byte));
                if (o_line_slow !== oldest.line_slow)
                    report_mismatch("line_slow", 16'(o_line_slow), 16'(oldest.line_slow));
                if (o_report_valid !== oldest.report_valid)
                    report_mismatch("report_valid", 16'(o_report_valid),
                                    16'(oldest.report_valid));
                if (o_report_is_error !== oldest.report_is_error)
                    report_mismatch("report_is_error", 16'(o_report_is_error),
                                    16'(oldest.report_is_error));
                if (o_error_code !== oldest.error_code)
                    report_mismatch("error_code", 16'(o_error_code), 16'(oldest.error_code));
                if (o_temperature_raw !== oldest.temperature_raw)
                    report_mismatch("temperature_raw", o_temperature_raw,
                                    oldest.temperature_raw);
            end
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output side stall pattern. A hold request stalls it for a long stretch.
    always @(posedge i_clk) begin : out_stall_gen
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                default:     i_out_stall <= (mode_left % 5 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offers one item and waits for its transfer. Bursts and gaps when enabled.
    task automatic send_item(input logic op, input logic [7:0] rx);
        int gap;
        if (gaps_on && burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(op, rx);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (line_result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register; only called while the block is drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ALARM_HIGH:   cfg_alarm_high = value;
            REG_ALARM_LOW:    cfg_alarm_low = value;
            REG_SENSOR_SETUP: cfg_setup = value;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // One tick and the echoes of a whole read, config and convert chain, as a
    // present sensor would return them. A frame may end early on a missing
    // presence pulse, and the chain may be cut after cut_after items.
    task automatic run_sensor_cycle(input logic [15:0] temp, input int nodev_pct,
                                    input int cut_after);
        int         sent;
        logic [3:0] len;
        logic       one;
        logic [7:0] echo;
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
        sent = 1;
        for (int s = 0; s < 3; s++) begin
            len = (s == 0) ? LEN_READ : (s == 1) ? LEN_CONFIG : LEN_CONVERT;
            if (sent == cut_after) return;
            sent++;
            if ($urandom_range(0, 99) < nodev_pct) begin
                send_item(OP_ECHO, SLOT_RESET);
                continue;
            end
            do echo = 8'($urandom_range(0, 255)); while (echo == SLOT_RESET);
            send_item(OP_ECHO, echo);
            for (int k = 0; k < 8 * len; k++) begin
                if (sent == cut_after) return;
                sent++;
                if (s == 0 && k >= 8 * TEMP_LO_IDX && k < 8 * (TEMP_HI_IDX + 1)) begin
                    one = temp[k - 8 * TEMP_LO_IDX];
                end else begin
                    one = 1'($urandom_range(0, 1));
                end
                // A zero comes back as a clean low byte or as line noise.
                echo = $urandom_range(0, 1) ? SLOT_ZERO : 8'($urandom_range(0, 255));
                send_item(OP_ECHO, one ? SLOT_ONE : echo);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Echoes while idle, a missing device, odd echo values and ticks that
    // arrive while a chain is still running.
    task automatic test_directed_special_cases();
        gaps_on = 1'b0;
        send_item(OP_ECHO, SLOT_ZERO);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_ECHO, SLOT_RESET);
        send_item(OP_TICK, SLOT_ONE);
        send_item(OP_ECHO, SLOT_RESET);
        send_item(OP_ECHO, SLOT_ZERO);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_ECHO, 8'hfe);
        send_item(OP_ECHO, 8'h7f);
        send_item(OP_ECHO, 8'h01);
        send_item(OP_ECHO, 8'h80);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_TICK, SLOT_ZERO);
        send_item(OP_ECHO, 8'he0);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_ECHO, SLOT_ZERO);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_ECHO, SLOT_ONE);
        send_item(OP_TICK, 8'h55);
        send_item(OP_ECHO, SLOT_RESET);
        drain_results();
    endtask

    // Runs full chains under extreme and ordinary register settings.
    task automatic test_register_settings();
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] setup;
        gaps_on = 1'b1;
        for (int n = 0; n < 4; n++) begin
            case (n)
                0: begin hi = '0; lo = '0; setup = '0; end
                1: begin hi = '1; lo = '1; setup = '1; end
                2: begin
                    hi = 8'($urandom_range(0, 255));
                    lo = 8'($urandom_range(0, 255));
                    setup = 8'($urandom_range(0, 255));
                end
                default: begin hi = ALARM_RESET; lo = ALARM_RESET; setup = SETUP_RESET; end
            endcase
            drain_results();
            write_reg(REG_ALARM_HIGH, hi);
            write_reg(REG_ALARM_LOW, lo);
            write_reg(REG_SENSOR_SETUP, setup);
            if (n == 0) begin
                write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            end
            run_sensor_cycle((n == 1) ? 16'hffff : 16'h0000, 0, -1);
        end
        drain_results();
    endtask

    // The output side holds off while items keep coming, so the block fills
    // up and stalls its input.
    task automatic test_receiver_hold();
        gaps_on = 1'b0;
        hold_token <= hold_token + 1;
        run_sensor_cycle(16'($urandom_range(0, 65535)), 0, -1);
        drain_results();
    endtask

    // The sender stops mid-chain until every result is in, then ticks again.
    task automatic test_sender_pause();
        gaps_on = 1'b1;
        run_sensor_cycle(16'h8000, 0, $urandom_range(20, 80));
        drain_results();
        run_sensor_cycle(16'h0001, 0, -1);
    endtask

    // Mostly whole chains with random content; some cut short, some with
    // missing devices, stray echoes and register changes between phases.
    task automatic test_random_cycles();
        int         goal;
        logic [15:0] temp;
        goal = items_effective + RANDOM_ITEMS;
        while (items_effective < goal) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0:       temp = 16'h0000;
                1:       temp = 16'hffff;
                2:       temp = 16'h8000;
                3:       temp = 16'h0001;
                default: temp = 16'($urandom_range(0, 65535));
            endcase
            run_sensor_cycle(temp, ($urandom_range(0, 3) == 0) ? 30 : 3,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 147) : -1);
            if ($urandom_range(0, 7) == 0) begin
                send_item(OP_ECHO, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 11) == 0) begin
                drain_results();
                write_reg(CFG_IDX_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_special_cases();
        test_register_settings();
        test_receiver_hold();
        test_sender_pause();
        test_random_cycles();
        drain_results();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/owts_pkg.sv
rtl/owts_store.sv
rtl/owts_ctrl.sv
rtl/owts_outq.sv
rtl/onewire_uart_temp_sequencer_top.sv
tb/tb_onewire_uart_temp_sequencer_top.sv
